// ===== sv/acli_pkg.sv =====
package acli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int WORD_W      = 3 * DATA_W;
  localparam int BIT_W       = $clog2(DATA_W);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_VALUE   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_STORED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

endpackage

// ===== sv/area_coeff_linear_interp_core.sv =====
// Piecewise-linear coefficient lookup by area.
// Input channel in_*: in_tuser carries the operation (append, query, clear),
// in_tdata the area and the two coefficients of an append. Every request
// produces exactly one result on out_*: out_tuser is the status, out_tdata
// the two coefficients (zero unless a value is given).
// An append, a clear or a query of an empty table goes from acceptance
// straight to the output state, which loads its result into the output
// register. A query scans the table one entry per cycle through the single
// read port of the breakpoint memory up to the first entry above the query
// area, or else up to the last entry. An end-point answer then goes to the
// output state. An interpolated answer first passes through the shared
// restoring divider and then the shared multiplier, once per coefficient.
// in_tready is high only while the sequencer is idle, so the next request
// is taken only after the result of the last one is loaded.
// The output register holds a result until it is taken; the sequencer can
// accept and work on the next request meanwhile, and waits before loading
// its own result if the previous one still stands.
// Reset (rst_n low, synchronous) empties the table and drops any result.
// Memory contents are not cleared; entries are only read below the count.
module area_coeff_linear_interp_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // area [31:0], coeff_one_in [63:32], coeff_two_in [95:64]
  input  logic [1:0]   in_tuser,   // op [1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // coeff_one_out [31:0], coeff_two_out [63:32]
  output logic [2:0]   out_tuser   // status [2:0]
);

  localparam int DW = acli_pkg::DATA_W;
  localparam int IW = acli_pkg::IDX_W;
  localparam int CW = acli_pkg::CNT_W;
  localparam int BW = acli_pkg::BIT_W;

  acli_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [DW-1:0]     q_r, q_nxt;
  logic              eq0_r, eq0_nxt;
  logic [DW-1:0]     f_c1_r, f_c1_nxt, f_c2_r, f_c2_nxt;
  logic [DW-1:0]     lo_area_r, lo_area_nxt;
  logic [DW-1:0]     lo_c1_r, lo_c1_nxt, lo_c2_r, lo_c2_nxt;
  logic [DW-1:0]     hi_c1_r, hi_c1_nxt, hi_c2_r, hi_c2_nxt;
  logic [DW-1:0]     den_r, den_nxt, rem_r, rem_nxt, quo_r, quo_nxt;
  logic [acli_pkg::BIT_W-1:0] bit_r, bit_nxt;
  logic              sel_r, sel_nxt;
  logic [DW-1:0]     mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [2*DW-1:0]   prod_r, prod_nxt;
  acli_pkg::stat_t   res_st_r, res_st_nxt;
  logic [DW-1:0]     res_c1_r, res_c1_nxt, res_c2_r, res_c2_nxt;
  logic              out_valid_r, out_valid_nxt;
  acli_pkg::stat_t   out_st_r, out_st_nxt;
  logic [DW-1:0]     out_c1_r, out_c1_nxt, out_c2_r, out_c2_nxt;

  // Breakpoint memory: {coeff_two, coeff_one, area} per entry.
  logic [acli_pkg::WORD_W-1:0] mem [acli_pkg::TABLE_DEPTH];
  logic [acli_pkg::WORD_W-1:0] rd_q;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;

  logic              accept;
  logic [DW-1:0]     rd_area, rd_c1, rd_c2;
  logic [DW:0]       div_t;
  logic              div_ge;
  logic [DW-1:0]     sel_lo, sel_hi;
  logic [DW:0]       diff;
  logic [2*DW-1:0]   mul_full;
  logic [DW-1:0]     step;
  logic [DW-1:0]     lerp;

  assign in_tready  = (state_r == acli_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {out_c2_r, out_c1_r};

  assign rd_area = rd_q[DW-1:0];
  assign rd_c1   = rd_q[2*DW-1:DW];
  assign rd_c2   = rd_q[3*DW-1:2*DW];

  assign wr_en = accept && (in_tuser == acli_pkg::OP_APPEND) &&
                 (cnt_r < CW'(acli_pkg::TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IW-1:0]] <= in_tdata;
    end
    rd_q <= mem[rd_addr];
  end

  // Shared datapath pieces.
  assign div_t    = {rem_r, 1'b0};
  assign div_ge   = div_t >= {1'b0, den_r};
  assign sel_lo   = sel_r ? lo_c2_r : lo_c1_r;
  assign sel_hi   = sel_r ? hi_c2_r : hi_c1_r;
  assign diff     = {sel_hi[DW-1], sel_hi} - {sel_lo[DW-1], sel_lo};
  assign mul_full = (2*DW)'(mag_r) * (2*DW)'(quo_r);
  // The step toward a lower coefficient rounds toward minus infinity.
  assign step     = prod_r[2*DW-1:DW] + DW'(neg_r && (prod_r[DW-1:0] != '0));
  assign lerp     = neg_r ? (sel_lo - step) : (sel_lo + step);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    eq0_nxt       = eq0_r;
    f_c1_nxt      = f_c1_r;
    f_c2_nxt      = f_c2_r;
    lo_area_nxt   = lo_area_r;
    lo_c1_nxt     = lo_c1_r;
    lo_c2_nxt     = lo_c2_r;
    hi_c1_nxt     = hi_c1_r;
    hi_c2_nxt     = hi_c2_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    sel_nxt       = sel_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    res_st_nxt    = res_st_r;
    res_c1_nxt    = res_c1_r;
    res_c2_nxt    = res_c2_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_c1_nxt    = out_c1_r;
    out_c2_nxt    = out_c2_r;
    rd_addr       = idx_r + IW'(1);

    unique case (state_r)
      acli_pkg::S_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          res_c1_nxt = '0;
          res_c2_nxt = '0;
          q_nxt      = in_tdata[DW-1:0];
          idx_nxt    = '0;
          state_nxt  = acli_pkg::S_OUT;
          priority if (in_tuser == acli_pkg::OP_APPEND) begin
            if (cnt_r < CW'(acli_pkg::TABLE_DEPTH)) begin
              cnt_nxt    = cnt_r + CW'(1);
              res_st_nxt = acli_pkg::ST_STORED;
            end else begin
              res_st_nxt = acli_pkg::ST_FULL;
            end
          end else if (in_tuser == acli_pkg::OP_CLEAR) begin
            cnt_nxt    = '0;
            res_st_nxt = acli_pkg::ST_CLEARED;
          end else if (cnt_r == '0) begin
            res_st_nxt = acli_pkg::ST_EMPTY;
          end else begin
            res_st_nxt = acli_pkg::ST_VALUE;
            state_nxt  = acli_pkg::S_SCAN;
          end
        end
      end

      acli_pkg::S_SCAN: begin
        if (idx_r == '0) begin
          eq0_nxt  = (q_r == rd_area);
          f_c1_nxt = rd_c1;
          f_c2_nxt = rd_c2;
        end
        if (q_r < rd_area) begin
          // First entry above the query: at or below entry 0 gives entry 0.
          if (idx_r == '0) begin
            res_c1_nxt = rd_c1;
            res_c2_nxt = rd_c2;
            state_nxt  = acli_pkg::S_OUT;
          end else if (eq0_r) begin
            res_c1_nxt = f_c1_r;
            res_c2_nxt = f_c2_r;
            state_nxt  = acli_pkg::S_OUT;
          end else begin
            hi_c1_nxt = rd_c1;
            hi_c2_nxt = rd_c2;
            den_nxt   = rd_area - lo_area_r;
            rem_nxt   = q_r - lo_area_r;
            quo_nxt   = '0;
            bit_nxt   = '1;
            state_nxt = acli_pkg::S_DIV;
          end
        end else begin
          lo_area_nxt = rd_area;
          lo_c1_nxt   = rd_c1;
          lo_c2_nxt   = rd_c2;
          if ({1'b0, idx_r} == cnt_r - CW'(1)) begin
            res_c1_nxt = rd_c1;
            res_c2_nxt = rd_c2;
            state_nxt  = acli_pkg::S_OUT;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end

      acli_pkg::S_DIV: begin
        // Restoring division, one quotient bit per cycle; the remainder
        // stays below the divisor so the quotient fits in 32 bits.
        rem_nxt = div_ge ? DW'(div_t - {1'b0, den_r}) : div_t[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], div_ge};
        bit_nxt = bit_r - BW'(1);
        if (bit_r == '0) begin
          sel_nxt   = 1'b0;
          state_nxt = acli_pkg::S_DIFF;
        end
      end

      acli_pkg::S_DIFF: begin
        // The magnitude of a 33-bit difference of two 32-bit values fits in 32 bits.
        neg_nxt   = diff[DW];
        mag_nxt   = diff[DW] ? DW'(-diff) : diff[DW-1:0];
        state_nxt = acli_pkg::S_MUL;
      end

      acli_pkg::S_MUL: begin
        prod_nxt  = mul_full;
        state_nxt = acli_pkg::S_ACC;
      end

      acli_pkg::S_ACC: begin
        if (!sel_r) begin
          res_c1_nxt = lerp;
          sel_nxt    = 1'b1;
          state_nxt  = acli_pkg::S_DIFF;
        end else begin
          res_c2_nxt = lerp;
          state_nxt  = acli_pkg::S_OUT;
        end
      end

      acli_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_c1_nxt    = res_c1_r;
          out_c2_nxt    = res_c2_r;
          state_nxt     = acli_pkg::S_IDLE;
        end
      end

      default: state_nxt = acli_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acli_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    q_r       <= q_nxt;
    eq0_r     <= eq0_nxt;
    f_c1_r    <= f_c1_nxt;
    f_c2_r    <= f_c2_nxt;
    lo_area_r <= lo_area_nxt;
    lo_c1_r   <= lo_c1_nxt;
    lo_c2_r   <= lo_c2_nxt;
    hi_c1_r   <= hi_c1_nxt;
    hi_c2_r   <= hi_c2_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    bit_r     <= bit_nxt;
    sel_r     <= sel_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    res_st_r  <= res_st_nxt;
    res_c1_r  <= res_c1_nxt;
    res_c2_r  <= res_c2_nxt;
    out_st_r  <= out_st_nxt;
    out_c1_r  <= out_c1_nxt;
    out_c2_r  <= out_c2_nxt;
  end

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(acli_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // A stored append grows the table by exactly one entry.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("append did not advance entry count");

  // A clear request empties the table.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == acli_pkg::OP_CLEAR) |=> cnt_r == '0)
    else $error("clear did not empty the table");

  // The divider remainder stays below the divisor during the division.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == acli_pkg::S_DIV |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  // Only a given value carries nonzero coefficients.
  a_zero_coeffs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != acli_pkg::ST_VALUE) |-> out_tdata == '0)
    else $error("coefficients nonzero without a value");

endmodule

// ===== tb/tb_area_coeff_linear_interp_core.sv =====
module tb_area_coeff_linear_interp_core;
  timeunit 1ns;
  timeprecision 1ps;

  // The spare op code is decoded by the block as a query.
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_WAIT  = 150;

  typedef struct packed {
    acli_pkg::stat_t status;
    logic [31:0]     coeff_one;
    logic [31:0]     coeff_two;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  // Shadow copy of the breakpoint table.
  logic [31:0] tbl_area [acli_pkg::TABLE_DEPTH];
  logic [31:0] tbl_coeff_one [acli_pkg::TABLE_DEPTH];
  logic [31:0] tbl_coeff_two [acli_pkg::TABLE_DEPTH];
  int          tbl_count;

  lookup_result_t pending_results [$];

  int errors;
  int reqs_sent;
  int hold_len;
  bit pace_on;
  bit stall_on;
  int n_stored, n_dropped, n_interp, n_endpoint, n_empty, n_cleared;

  area_coeff_linear_interp_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lo + floor((hi - lo) * ratio / 2^32), with the floor toward minus infinity.
  function automatic logic [31:0] interp_coeff(input logic [31:0] lo, input logic [31:0] hi,
                                                input logic [31:0] ratio);
    longint      lo_s;
    longint      diff;
    longint      step;
    logic [63:0] mag;
    logic [63:0] prod;
    lo_s = longint'($signed(lo));
    diff = longint'($signed(hi)) - lo_s;
    mag  = (diff < 0) ? -diff : diff;
    prod = mag * {32'd0, ratio};
    step = longint'(prod[63:32]);
    if (diff < 0) begin
      step = -(step + longint'(prod[31:0] != 32'd0));
    end
    interp_coeff = 32'(lo_s + step);
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 9))
      0: rand_coeff = 32'h7FFF_FFFF;
      1: rand_coeff = 32'h8000_0000;
      2: rand_coeff = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: rand_coeff = $urandom;
    endcase
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [31:0] area,
                                 input logic [31:0] c1, input logic [31:0] c2);
    lookup_result_t r;
    int             h;
    int             lo_idx;
    logic [63:0]    num;
    logic [63:0]    den;
    logic [63:0]    ratio;
    r.status    = acli_pkg::ST_VALUE;
    r.coeff_one = 32'd0;
    r.coeff_two = 32'd0;
    case (op)
      acli_pkg::OP_APPEND: begin
        if (tbl_count < acli_pkg::TABLE_DEPTH) begin
          tbl_area[tbl_count]      = area;
          tbl_coeff_one[tbl_count] = c1;
          tbl_coeff_two[tbl_count] = c2;
          tbl_count++;
          r.status = acli_pkg::ST_STORED;
          n_stored++;
        end else begin
          r.status = acli_pkg::ST_FULL;
          n_dropped++;
        end
      end
      acli_pkg::OP_CLEAR: begin
        tbl_count = 0;
        r.status  = acli_pkg::ST_CLEARED;
        n_cleared++;
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = acli_pkg::ST_EMPTY;
          n_empty++;
        end else if (tbl_count == 1) begin
          r.coeff_one = tbl_coeff_one[0];
          r.coeff_two = tbl_coeff_two[0];
          n_endpoint++;
        end else begin
          h = tbl_count;
          for (int i = 0; i < tbl_count; i++) begin
            if (area < tbl_area[i]) begin
              h = i;
              break;
            end
          end
          if (h == tbl_count) begin
            r.coeff_one = tbl_coeff_one[tbl_count - 1];
            r.coeff_two = tbl_coeff_two[tbl_count - 1];
            n_endpoint++;
          end else if (area <= tbl_area[0]) begin
            r.coeff_one = tbl_coeff_one[0];
            r.coeff_two = tbl_coeff_two[0];
            n_endpoint++;
          end else begin
            lo_idx      = h - 1;
            num         = {area - tbl_area[lo_idx], 32'd0};
            den         = {32'd0, tbl_area[h] - tbl_area[lo_idx]};
            ratio       = num / den;
            r.coeff_one = interp_coeff(tbl_coeff_one[lo_idx], tbl_coeff_one[h], ratio[31:0]);
            r.coeff_two = interp_coeff(tbl_coeff_two[lo_idx], tbl_coeff_two[h], ratio[31:0]);
            n_interp++;
          end
        end
      end
    endcase
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_request(input logic [1:0] op, input logic [31:0] area,
                              input logic [31:0] c1, input logic [31:0] c2);
    int gap;
    gap = pace_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {c2, c1, area};
    do @(posedge clk); while (!in_tready);
    predict_request(op, area, c1, c2);
    reqs_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_edges();
    send_request(acli_pkg::OP_QUERY, 32'h0000_0000, 32'd0, 32'd0);
    send_request(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(acli_pkg::OP_CLEAR, 32'd0, 32'd0, 32'd0);
    send_request(acli_pkg::OP_APPEND, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(acli_pkg::OP_QUERY, 32'h0000_0000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0);
    // Full-scale swing between neighbors, falling in one coefficient.
    send_request(acli_pkg::OP_APPEND, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(acli_pkg::OP_QUERY, 32'h0001_0000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'h0000_8000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'h0002_0000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'h0002_FFFF, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'h0003_0000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'h0001_0001, 32'd0, 32'd0);
    // A repeated area, then one out of order.
    send_request(acli_pkg::OP_APPEND, 32'h0003_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(acli_pkg::OP_APPEND, 32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_request(acli_pkg::OP_QUERY, 32'h0002_8000, 32'd0, 32'd0);
    send_request(OP_SPARE, 32'h0001_8000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h1000_0000, 32'hF000_0000);
    send_request(acli_pkg::OP_QUERY, 32'hFFFF_FFFE, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_request(acli_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(acli_pkg::OP_QUERY, 32'h0000_0000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_APPEND, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(acli_pkg::OP_QUERY, 32'h0000_0000, 32'd0, 32'd0);
    send_request(acli_pkg::OP_CLEAR, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_full_table();
    logic [31:0] bp_area [acli_pkg::TABLE_DEPTH];
    logic [31:0] a;
    int          i;
    a = $urandom_range(0, 32'h00FF_FFFF);
    for (i = 0; i < acli_pkg::TABLE_DEPTH; i++) begin
      bp_area[i] = a;
      send_request(acli_pkg::OP_APPEND, a, rand_coeff(), rand_coeff());
      a = a + $urandom_range(1, 32'h03FF_FFFF);
    end
    for (int j = 0; j < 12; j++) begin
      i = $urandom_range(acli_pkg::TABLE_DEPTH / 2, acli_pkg::TABLE_DEPTH - 2);
      send_request(acli_pkg::OP_QUERY, $urandom_range(bp_area[i + 1], bp_area[i]),
                   $urandom, $urandom);
    end
    send_request(acli_pkg::OP_QUERY, bp_area[acli_pkg::TABLE_DEPTH - 1], 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_request(acli_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(acli_pkg::OP_APPEND, $urandom, $urandom, $urandom);
    send_request(acli_pkg::OP_QUERY, bp_area[1] - 32'd1, 32'd0, 32'd0);
    send_request(acli_pkg::OP_CLEAR, 32'd0, 32'd0, 32'd0);
    send_request(acli_pkg::OP_QUERY, $urandom, 32'd0, 32'd0);
  endtask

  // The sink stops taking results for a long stretch while requests keep
  // coming back to back, then the source waits for everything to come out.
  task automatic test_backpressure();
    logic [31:0] a;
    send_request(acli_pkg::OP_CLEAR, 32'd0, 32'd0, 32'd0);
    a = 32'h0000_1000;
    for (int i = 0; i < 8; i++) begin
      send_request(acli_pkg::OP_APPEND, a, rand_coeff(), rand_coeff());
      a = a + $urandom_range(1, 32'h0010_0000);
    end
    wait_results_drained();
    pace_on  = 1'b0;
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_request(acli_pkg::OP_QUERY, $urandom_range(a, 0), $urandom, $urandom);
    end
    wait_results_drained();
    pace_on = 1'b1;
  endtask

  // Usually clear, then load a table (mostly ascending), then query it from every side.
  task automatic test_random_tables(input int target);
    logic [31:0] bp_area [acli_pkg::TABLE_DEPTH];
    logic [31:0] a;
    logic [31:0] prev;
    logic [31:0] q;
    int          n;
    int          m;
    int          k;
    int          mode;
    int          i;
    while (reqs_sent < target) begin
      pace_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) != 0) begin
        send_request(acli_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
      end
      k = $urandom_range(0, 9);
      n = (k == 0) ? $urandom_range(0, 1) :
          (k == 1) ? $urandom_range(20, acli_pkg::TABLE_DEPTH + 2) : $urandom_range(2, 10);
      mode = $urandom_range(0, 9);
      prev = $urandom >> $urandom_range(0, 31);
      for (i = 0; i < n; i++) begin
        if (mode == 0) begin
          a = $urandom;
        end else if (mode < 3) begin
          a = prev + $urandom_range(0, 3);
        end else begin
          a = prev + $urandom_range(0, (32'hFFFF_FFFF - prev) / (n - i));
        end
        prev = a;
        if (i < acli_pkg::TABLE_DEPTH) begin
          bp_area[i] = a;
        end
        send_request(acli_pkg::OP_APPEND, a, rand_coeff(), rand_coeff());
      end
      m = (n < acli_pkg::TABLE_DEPTH) ? n : acli_pkg::TABLE_DEPTH;
      for (int j = $urandom_range(4, 20); j > 0; j--) begin
        k = $urandom_range(0, 9);
        if (k == 0) begin
          send_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end else begin
          i = (m >= 2) ? $urandom_range(0, m - 2) : 0;
          if (m < 2 || k == 1) begin
            q = $urandom;
          end else if (k == 2) begin
            q = bp_area[i];
          end else if (k == 3) begin
            q = bp_area[0] - $urandom_range(0, 2);
          end else if (k == 4) begin
            q = bp_area[m - 1] + $urandom_range(0, 2);
          end else if (bp_area[i] <= bp_area[i + 1]) begin
            q = $urandom_range(bp_area[i + 1], bp_area[i]);
          end else begin
            q = $urandom;
          end
          send_request(($urandom_range(0, 7) == 0) ? OP_SPARE : acli_pkg::OP_QUERY, q,
                       $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin : result_sink
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
      end else begin
        n = stall_on ? $urandom_range(0, 16) : 0;
      end
      if (n > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d data %h", $time, out_tuser,
                 out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
        end
        if (out_tdata[31:0] !== want.coeff_one) begin
          errors++;
          $display("%0t: coeff_one expected %h actual %h", $time, want.coeff_one,
                   out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.coeff_two) begin
          errors++;
          $display("%0t: coeff_two expected %h actual %h", $time, want.coeff_two,
                   out_tdata[63:32]);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL area_coeff_linear_interp_core");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    tbl_count = 0;
    errors    = 0;
    reqs_sent = 0;
    hold_len  = 0;
    pace_on   = 1'b1;
    stall_on  = 1'b1;
    n_stored = 0; n_dropped = 0; n_interp = 0; n_endpoint = 0; n_empty = 0; n_cleared = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_full_table();
    test_backpressure();
    test_random_tables(1600);

    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d requests: %0d appends stored, %0d dropped on a full table,",
             reqs_sent, n_stored, n_dropped);
    $display("%0d interpolated lookups, %0d end or single-entry lookups, %0d empty, %0d clears.",
             n_interp, n_endpoint, n_empty, n_cleared);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS area_coeff_linear_interp_core");
    end else begin
      $display("FAIL area_coeff_linear_interp_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/acli_pkg.sv
sv/area_coeff_linear_interp_core.sv
tb/tb_area_coeff_linear_interp_core.sv
